[hw/rtl/spq_pkg.sv]
// shared types and codes for the sorted priority queue
`default_nettype none

package spq_pkg;

	// default number of entry cells
	localparam int SPQ_CAPACITY = 16;

	// data path widths
	localparam int DATA_W = 32;
	localparam int OCC_W  = 5;

	// operation codes
	typedef enum logic {
		CMD_INSERT  = 1'b0,
		CMD_DEQUEUE = 1'b1
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one stored entry as seen by the neighbor cells
	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} entry_t;

	// operation broadcast to every cell
	typedef struct packed {
		logic                     ins;
		logic                     deq;
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] prio;
	} cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/spq_cell.sv]
// one slot of the sorted chain: holds an entry, shifts toward tail on insert, toward head on dequeue
`default_nettype none

module spq_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire spq_pkg::cell_ctl_t ctl,
	input  wire spq_pkg::entry_t   left_entry,
	input  wire logic              left_place,
	input  wire spq_pkg::entry_t   right_entry,
	output spq_pkg::entry_t        entry,
	output logic                   place
);
	import spq_pkg::*;

	logic                     valid_q;
	logic signed [DATA_W-1:0] value_q;
	logic signed [DATA_W-1:0] prio_q;
	entry_t                   own;
	entry_t                   nxt;

	assign own   = '{valid: valid_q, value: value_q, prio: prio_q};
	assign entry = own;

	// new entry belongs here or further toward the head
	assign place = !valid_q || (prio_q < ctl.prio);

	// next contents of the slot
	always_comb begin
		nxt = own;
		if (ctl.ins) begin
			if (left_place) begin
				nxt = left_entry;
			end else if (place) begin
				nxt = '{valid: 1'b1, value: ctl.value, prio: ctl.prio};
			end
		end else if (ctl.deq) begin
			nxt = right_entry;
		end
	end

	// occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		value_q <= nxt.value;
		prio_q  <= nxt.prio;
	end

endmodule

`default_nettype wire

[hw/rtl/sorted_priority_queue.sv]
// Sorted priority queue, highest priority first, built as a chain of CAPACITY entry cells.
// Every cell compares its priority with the incoming one in parallel and the whole chain
// shifts together, so the block takes one operation per clock unless stalled and presents its
// result in the cycle after the transfer. A single output register holds the result; while it
// waits under out_stall the input stalls, and a new transfer is taken in the same cycle the
// waiting result leaves. Ties are served in arrival order. An insert into a full queue is
// dropped with status full, a dequeue on an empty queue returns status empty. Occupancy
// reports the low five bits of the entry count.
`default_nettype none

module sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             command,
	input  wire logic signed [spq_pkg::DATA_W-1:0] item_value,
	input  wire logic signed [spq_pkg::DATA_W-1:0] item_priority,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [spq_pkg::DATA_W-1:0]      out_value,
	output logic signed [spq_pkg::DATA_W-1:0]      out_priority,
	output logic [1:0]                            status,
	output logic [spq_pkg::OCC_W-1:0]             occupancy
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	entry_t              cell_entry [CAPACITY];
	logic [CAPACITY-1:0] cell_place;
	entry_t              left_in    [CAPACITY];
	logic [CAPACITY-1:0] left_pl;
	entry_t              right_in   [CAPACITY];
	cell_ctl_t           ctl;

	logic                  in_xfer;
	logic                  is_deq;
	logic                  q_empty;
	logic                  q_full;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic [CNT_W+OCC_W-1:0] occ_ext;

	logic                     res_valid_q;
	logic signed [DATA_W-1:0] res_value_q;
	logic signed [DATA_W-1:0] res_prio_q;
	status_t                  res_status_q;
	logic [OCC_W-1:0]         res_occ_q;

	// handshake
	assign in_stall = res_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;
	assign is_deq   = (cmd_t'(command) == CMD_DEQUEUE);

	assign q_empty = !cell_entry[0].valid;
	assign q_full  = cell_entry[CAPACITY-1].valid;

	// operation broadcast, suppressed when it cannot take effect
	assign ctl = '{ins: in_xfer && !is_deq && !q_full,
	               deq: in_xfer && is_deq && !q_empty,
	               value: item_value, prio: item_priority};

	// cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_in[i] = '0;
			assign left_pl[i] = 1'b0;
		end else begin : g_mid
			assign left_in[i] = cell_entry[i-1];
			assign left_pl[i] = cell_place[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_in[i] = '0;
		end else begin : g_body
			assign right_in[i] = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_entry  (left_in[i]),
			.left_place  (left_pl[i]),
			.right_entry (right_in[i]),
			.entry       (cell_entry[i]),
			.place       (cell_place[i])
		);
	end

	// entry count
	always_comb begin
		count_d = count_q;
		if (ctl.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctl.deq) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	assign occ_ext = {{OCC_W{1'b0}}, count_d};

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_xfer) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_value_q  <= ctl.deq ? cell_entry[0].value : '0;
			res_prio_q   <= ctl.deq ? cell_entry[0].prio : '0;
			res_occ_q    <= occ_ext[OCC_W-1:0];
			if (is_deq) begin
				res_status_q <= q_empty ? ST_EMPTY : ST_OK;
			end else begin
				res_status_q <= q_full ? ST_FULL : ST_OK;
			end
		end
	end

	assign out_valid    = res_valid_q;
	assign out_value    = res_value_q;
	assign out_priority = res_prio_q;
	assign status       = res_status_q;
	assign occupancy    = res_occ_q;

	// head slot is filled exactly when the count is nonzero
	a_head_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) == cell_entry[0].valid)
		else $error("head cell occupancy disagrees with entry count");

	// tail slot is filled exactly when the queue is full
	a_tail_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CNT_W'(CAPACITY)) == cell_entry[CAPACITY-1].valid)
		else $error("tail cell occupancy disagrees with entry count");

	// a dequeue on a nonempty queue returns the head it saw
	a_deq_head: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && is_deq && cell_entry[0].valid) |=>
		(out_valid && status == ST_OK && out_priority == $past(cell_entry[0].prio)))
		else $error("dequeue did not return the head entry");

	// neighboring filled cells stay in priority order
	for (genvar k = 1; k < CAPACITY; k++) begin : g_order
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			cell_entry[k].valid |-> (cell_entry[k-1].valid &&
			cell_entry[k-1].prio >= cell_entry[k].prio))
			else $error("cell chain out of priority order");
	end

endmodule

`default_nettype wire
